/* rtl/swm_pkg.sv */
// Shared types and constants for the sliding window maximum core.
`default_nettype none
package swm_pkg;

	localparam int DATA_W         = 32;
	localparam int WS_W           = 6;
	localparam int MAX_WINDOW_DEF = 32;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [WS_W-1:0]          ws_t;

	localparam ws_t     WS_RESET   = 6'd3;
	// neutral element for a signed max
	localparam sample_t SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic load;
		logic produce;
	} tree_ctl_t;

	typedef struct packed {
		logic done;
		logic produce;
	} tree_sts_t;

endpackage
`default_nettype wire

/* rtl/swm_cell.sv */
// One history cell: holds a sample, passes it on, masks it outside the window.
`default_nettype none
module swm_cell #(
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 shift,
	input  swm_pkg::sample_t    d,
	input  swm_pkg::ws_t        window_size,
	output swm_pkg::sample_t    q,
	output swm_pkg::sample_t    lane
);
	import swm_pkg::*;

	sample_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q    = data_q;
	assign lane = (32'(IDX) < 32'(window_size)) ? data_q : SAMPLE_MIN;

endmodule
`default_nettype wire

/* rtl/swm_max_tree.sv */
// Registered binary tree of signed max nodes over the masked cell values.
`default_nettype none
module swm_max_tree #(
	parameter int LEAVES = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  swm_pkg::tree_ctl_t  ctl,
	input  swm_pkg::sample_t    leaf_d [LEAVES],
	output swm_pkg::tree_sts_t  sts,
	output swm_pkg::sample_t    max_val
);
	import swm_pkg::*;

	localparam int LEVELS = $clog2(LEAVES);
	localparam int NODES  = 2 * LEAVES - 1;

	// heap layout: node 0 is the root, leaves at LEAVES-1 .. NODES-1
	sample_t              node_q [NODES];
	logic    [LEVELS:0]   vld_q;
	logic                 prod_q;

	genvar i;
	generate
		for (i = 0; i < NODES; i++) begin : g_node
			localparam int DEPTH = $clog2(i + 2) - 1;
			if (i >= LEAVES - 1) begin : g_leaf
				always_ff @(posedge clk) begin
					if (ctl.load) begin
						node_q[i] <= leaf_d[i - (LEAVES - 1)];
					end
				end
			end else begin : g_inner
				always_ff @(posedge clk) begin
					if (vld_q[LEVELS - DEPTH - 1]) begin
						node_q[i] <= (node_q[2*i+1] < node_q[2*i+2]) ?
							node_q[2*i+2] : node_q[2*i+1];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			prod_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[LEVELS:0] << 1} | {{LEVELS{1'b0}}, ctl.load};
			if (ctl.load) begin
				prod_q <= ctl.produce;
			end
		end
	end

	assign sts.done    = vld_q[LEVELS];
	assign sts.produce = prod_q;
	assign max_val     = node_q[0];

endmodule
`default_nettype wire

/* rtl/sliding_window_maximum_core.sv */
// Sliding window maximum: shift chain of cells feeding a registered max tree.
//
// Input words arrive on s_tvalid/s_tready: s_tdata carries a signed sample,
// s_tuser flags the first sample of a new array (the fill count restarts).
// Each accepted word shifts into the cell chain. Once window_size samples of
// the current array are held, the word yields the signed maximum of the
// latest window_size samples on m_tdata; before that, or with window_size 0
// or above MAX_WINDOW, it yields nothing.
// An accepted word shifts into the cells, loads the tree leaves, passes the
// LEVELS levels of the compare tree (clog2 of MAX_WINDOW rounded up to a
// power of two); a produced maximum is registered onto m_tdata. One word is
// in flight at a time; the next is taken once the tree is done with it and
// any result sits in the output register, waiting for the receiver. If it
// stalls, the next result holds in the tree root and input stalls until the
// output register frees. Reset clears the fill count, sets window_size to 3
// and empties the output. Users write window_size through cfg_we/cfg_wdata
// only while no word is in flight; the core does not enforce this.
`default_nettype none
module sliding_window_maximum_core #(
	parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  swm_pkg::sample_t    s_tdata,   // [31:0] sample
	input  wire                 s_tuser,   // [0] start_of_array
	output logic                m_tvalid,
	input  wire                 m_tready,
	output swm_pkg::sample_t    m_tdata,   // [31:0] window_max
	input  wire                 cfg_we,
	input  swm_pkg::ws_t        cfg_wdata
);
	import swm_pkg::*;

	localparam int LEAVES = 1 << $clog2(MAX_WINDOW);
	localparam int FW     = $clog2(MAX_WINDOW + 1);

	ws_t           window_size_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_base;
	logic [FW-1:0] fill_nx;
	logic          produce;
	logic          accept;
	logic          busy_q;
	logic          ld_q;
	logic          prod_q;
	logic          pend_q;
	logic          out_free;
	logic          xfer;
	logic          m_tvalid_q;
	sample_t       m_tdata_q;
	sample_t       max_val;
	tree_ctl_t     tctl;
	tree_sts_t     tsts;

	sample_t       chain_q [MAX_WINDOW];
	sample_t       leaf_d  [LEAVES];

	assign accept = s_tvalid && s_tready;
	assign s_tready = !busy_q;

	genvar i;
	generate
		for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
			swm_cell #(.IDX(i)) u_cell (
				.clk         (clk),
				.shift       (accept),
				.d           ((i == 0) ? s_tdata : chain_q[(i == 0) ? 0 : i - 1]),
				.window_size (window_size_q),
				.q           (chain_q[i]),
				.lane        (leaf_d[i])
			);
		end
		for (i = MAX_WINDOW; i < LEAVES; i++) begin : g_pad
			assign leaf_d[i] = SAMPLE_MIN;
		end
	endgenerate

	always_comb begin
		fill_base = s_tuser ? '0 : fill_q;
		fill_nx   = (fill_base == FW'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;
		produce   = (window_size_q != '0) &&
		            (32'(window_size_q) <= 32'(MAX_WINDOW)) &&
		            (32'(fill_nx) >= 32'(window_size_q));
	end

	assign tctl.load    = ld_q;
	assign tctl.produce = prod_q;

	swm_max_tree #(.LEAVES(LEAVES)) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tctl),
		.leaf_d  (leaf_d),
		.sts     (tsts),
		.max_val (max_val)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign xfer     = ((tsts.done && tsts.produce) || pend_q) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
			fill_q        <= '0;
			busy_q        <= 1'b0;
			ld_q          <= 1'b0;
			prod_q        <= 1'b0;
			pend_q        <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
			end
			ld_q <= accept;
			if (accept) begin
				fill_q <= fill_nx;
				prod_q <= produce;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (xfer || (tsts.done && !tsts.produce)) begin
				busy_q <= 1'b0;
			end
			if (xfer) begin
				pend_q <= 1'b0;
			end else if (tsts.done && tsts.produce) begin
				pend_q <= 1'b1;
			end
			if (xfer) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			m_tdata_q <= max_val;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_done_busy : assert property (@(posedge clk) disable iff (!arst_n)
		tsts.done |-> busy_q)
		else $error("tree finished with no word in flight");

	a_pend_busy : assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (busy_q && !s_tready))
		else $error("pending result while input open");

	a_accept_busy : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && ld_q))
		else $error("accepted word not launched");

	a_done_single : assert property (@(posedge clk) disable iff (!arst_n)
		tsts.done |-> !pend_q)
		else $error("tree result overwrote a pending result");

endmodule
`default_nettype wire
